// ----- rtl/decimal_dot_matrix_renderer_defines.svh -----
// assertion macros for the decimal dot-matrix renderer
`ifndef DECIMAL_DOT_MATRIX_RENDERER_DEFINES_SVH
`define DECIMAL_DOT_MATRIX_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS
// checked on clk, quiet while rst is high
`define DDMR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ddmr assertion failed");
// checked on clk, also during reset
`define DDMR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ddmr assertion failed");
`else
`define DDMR_ASSERT(lbl, prop)
`define DDMR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/ddmr_pkg.sv -----
// types, constants, glyph table and digit helpers for the dot-matrix renderer
package ddmr_pkg;

  localparam int MAX_DIGITS = 4;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int VALUE_W    = 14;
  localparam int ROW_W      = 3;
  localparam int COUNT_W    = 3;
  localparam int DIGIT_W    = 4;
  localparam int REM_W      = 10;
  localparam int REM2_W     = 7;
  localparam int VALUE_CAP  = 9999;

  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      if (r <= VALUE_CAP) begin
        r = r * 10;
      end
    end
    return r;
  endfunction

  localparam int VALUE_LIMIT =
    (pow10(MAX_DIGITS) - 1 > VALUE_CAP) ? VALUE_CAP : pow10(MAX_DIGITS) - 1;

  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [GLYPH_COLS-1:0] pix_t;
  typedef logic [REM_W-1:0]      rem_t;
  typedef logic [REM2_W-1:0]     rem2_t;

  localparam row_t LAST_ROW = row_t'(GLYPH_ROWS - 1);

  // bit4 is the leftmost column
  localparam pix_t GLYPH_TBL [10][GLYPH_ROWS] = '{
    '{5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31},
    '{5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd1,  5'd1,  5'd31, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd1,  5'd1,  5'd31, 5'd1,  5'd1,  5'd31},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd16, 5'd16, 5'd31, 5'd1,  5'd1,  5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd31, 5'd17, 5'd17, 5'd31},
    '{5'd31, 5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd31},
    '{5'd31, 5'd17, 5'd17, 5'd31, 5'd1,  5'd1,  5'd31}
  };

  function automatic pix_t glyph_row(input digit_t d, input row_t r);
    pix_t p;
    p = '0;
    if (d <= digit_t'(9) && r <= LAST_ROW) begin
      p = GLYPH_TBL[d][r];
    end
    return p;
  endfunction

  // compare ladders: each compare is independent, the last hit wins
  function automatic digit_t thousands_of(input value_t v);
    digit_t d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= value_t'(k * 1000)) begin
        d = digit_t'(k);
      end
    end
    return d;
  endfunction

  function automatic digit_t hundreds_of(input rem_t v);
    digit_t d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= rem_t'(k * 100)) begin
        d = digit_t'(k);
      end
    end
    return d;
  endfunction

  function automatic digit_t tens_of(input rem2_t v);
    digit_t d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= rem2_t'(k * 10)) begin
        d = digit_t'(k);
      end
    end
    return d;
  endfunction

endpackage

// ----- rtl/decimal_dot_matrix_renderer.sv -----
// decimal dot-matrix renderer: value in, seven glyph row transfers out
//
//  channel | group              | payload
//  --------+--------------------+------------------------------------------------
//  input   | s_tvalid/s_tready  | s_tdata: value[13:0]
//  output  | m_tvalid/m_tready  | m_tdata: row_index, digit_count, pixels_pos0..3
//          |                    | m_tlast: last_row
//
// each value gives seven output transfers, one per cycle while m_tready is high,
// so the row emitter sets the pace of a steady stream. a value passes an input
// register and a digit register before the emitter.
// rst clears all valid flags; no clearing pass is needed.
// the next value is loaded in the same cycle as the last row transfer of the
// previous one; a stalled m_tready holds everything upstream once full.
`include "decimal_dot_matrix_renderer_defines.svh"

module decimal_dot_matrix_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value[13:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // row_index[2:0], digit_count[5:3], pixels_pos0[10:6],
                                 // pixels_pos1[15:11], pixels_pos2[20:16],
                                 // pixels_pos3[25:21]
  output logic        m_tlast    // last_row
);

  // input register
  logic                    a_valid;
  ddmr_pkg::value_t        a_value;
  // digit register
  logic                    b_valid;
  ddmr_pkg::digit_t        b_th;
  ddmr_pkg::rem_t          b_rem;
  // row emitter
  logic                    busy;
  ddmr_pkg::row_t          row;
  ddmr_pkg::count_t        count;
  ddmr_pkg::digit_t        pos_dig [4];
  logic [3:0]              pos_on;

  logic                    load;
  logic                    b_ready;
  logic                    a_adv;
  logic                    m_xfer;
  ddmr_pkg::value_t        s_value;
  ddmr_pkg::value_t        clamped;
  ddmr_pkg::digit_t        th_next;
  ddmr_pkg::value_t        rem_wide;
  ddmr_pkg::digit_t        hu;
  ddmr_pkg::rem_t          rem2_wide;
  ddmr_pkg::rem2_t         rem2;
  ddmr_pkg::digit_t        te;
  ddmr_pkg::rem2_t         one_wide;
  ddmr_pkg::digit_t        dig_lsd [4];
  ddmr_pkg::count_t        count_next;
  ddmr_pkg::count_t        sel;
  ddmr_pkg::digit_t        pos_dig_next [4];
  logic [3:0]              pos_on_next;
  ddmr_pkg::pix_t          pix [4];

  assign m_xfer   = m_tvalid && m_tready;
  assign load     = b_valid && (!busy || (m_tready && row == ddmr_pkg::LAST_ROW));
  assign b_ready  = !b_valid || load;
  assign a_adv    = a_valid && b_ready;
  assign s_tready = !a_valid || b_ready;

  assign s_value  = s_tdata[ddmr_pkg::VALUE_W-1:0];
  assign clamped  = (s_value > ddmr_pkg::value_t'(ddmr_pkg::VALUE_LIMIT))
                  ? ddmr_pkg::value_t'(ddmr_pkg::VALUE_LIMIT) : s_value;

  // thousands split from the input register
  always_comb begin
    th_next  = ddmr_pkg::thousands_of(a_value);
    rem_wide = a_value - ddmr_pkg::value_t'(th_next) * ddmr_pkg::value_t'(1000);
  end

  // remaining digits and left-aligned placement
  always_comb begin
    hu        = ddmr_pkg::hundreds_of(b_rem);
    rem2_wide = b_rem - ddmr_pkg::rem_t'(hu) * ddmr_pkg::rem_t'(100);
    rem2      = rem2_wide[ddmr_pkg::REM2_W-1:0];
    te        = ddmr_pkg::tens_of(rem2);
    one_wide  = rem2 - ddmr_pkg::rem2_t'(te) * ddmr_pkg::rem2_t'(10);
    dig_lsd[0] = one_wide[ddmr_pkg::DIGIT_W-1:0];
    dig_lsd[1] = te;
    dig_lsd[2] = hu;
    dig_lsd[3] = b_th;
    if (b_th != '0) begin
      count_next = ddmr_pkg::count_t'(4);
    end else if (hu != '0) begin
      count_next = ddmr_pkg::count_t'(3);
    end else if (te != '0) begin
      count_next = ddmr_pkg::count_t'(2);
    end else begin
      count_next = ddmr_pkg::count_t'(1);
    end
    sel = '0;
    for (int p = 0; p < 4; p++) begin
      sel             = count_next - ddmr_pkg::count_t'(p + 1);
      pos_on_next[p]  = ddmr_pkg::count_t'(p) < count_next;
      pos_dig_next[p] = dig_lsd[sel[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      busy    <= 1'b0;
      row     <= '0;
    end else begin
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (load) begin
        busy <= 1'b1;
        row  <= '0;
      end else if (m_xfer) begin
        if (row == ddmr_pkg::LAST_ROW) begin
          busy <= 1'b0;
        end else begin
          row <= row + ddmr_pkg::row_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_value <= clamped;
    end
    if (a_adv) begin
      b_th  <= th_next;
      b_rem <= rem_wide[ddmr_pkg::REM_W-1:0];
    end
    if (load) begin
      count   <= count_next;
      pos_on  <= pos_on_next;
      pos_dig <= pos_dig_next;
    end
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      pix[p] = pos_on[p] ? ddmr_pkg::glyph_row(pos_dig[p], row) : '0;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = (row == ddmr_pkg::LAST_ROW);
  assign m_tdata  = {6'b0, pix[3], pix[2], pix[1], pix[0], count, row};

  `DDMR_ASSERT(a_rem_range, b_valid |-> b_rem < ddmr_pkg::rem_t'(1000))
  `DDMR_ASSERT(a_count_range, m_tvalid |-> (count != '0 && count <= ddmr_pkg::count_t'(4)))
  `DDMR_ASSERT(a_row_step, (m_xfer && !m_tlast) |=> row == $past(row) + ddmr_pkg::row_t'(1))
  `DDMR_ASSERT(a_done_idle, (m_xfer && m_tlast && !b_valid) |=> !m_tvalid)
  `DDMR_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (!m_tvalid && !b_valid && !a_valid))

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the decimal dot-matrix renderer
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_WAIT    = 19;

  // own copy of the 5x7 font, bit4 is the leftmost column
  localparam logic [4:0] FONT [10][7] = '{
    '{5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31},
    '{5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd1,  5'd1,  5'd31, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd1,  5'd1,  5'd31, 5'd1,  5'd1,  5'd31},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd16, 5'd16, 5'd31, 5'd1,  5'd1,  5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd31, 5'd17, 5'd17, 5'd31},
    '{5'd31, 5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1 },
    '{5'd31, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd31},
    '{5'd31, 5'd17, 5'd17, 5'd31, 5'd1,  5'd1,  5'd31}
  };

  typedef struct packed {
    ddmr_pkg::row_t   row;
    ddmr_pkg::count_t count;
    logic [3:0][4:0]  pix;    // pix[0] is the leftmost digit
    logic             last;
  } glyph_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;

  glyph_row_t rows_due[$];
  int         mismatches;
  int         cycles;
  int         stall_left;
  int         stall_draw;
  bit         no_idle;

  decimal_dot_matrix_renderer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // expected seven rows for one accepted value
  function automatic void render_value(input logic [13:0] v);
    int         n;
    int         ndig;
    int         dig [4];
    glyph_row_t r;
    n = v;
    ndig = 0;
    if (n > ddmr_pkg::VALUE_LIMIT) begin
      n = ddmr_pkg::VALUE_LIMIT;
    end
    do begin
      if (ndig < 4) begin
        dig[ndig] = n % 10;
        ndig++;
      end
      n = n / 10;
    end while (n != 0);
    for (int row = 0; row < 7; row++) begin
      r.row = ddmr_pkg::row_t'(row);
      r.count = ddmr_pkg::count_t'(ndig);
      for (int p = 0; p < 4; p++) begin
        r.pix[p] = (p < ndig) ? FONT[dig[ndig - 1 - p]][row] : 5'd0;
      end
      r.last = (row == 6);
      rows_due.push_back(r);
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_row();
    glyph_row_t want;
    if (rows_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected row transfer, expected none actual tdata=%h tlast=%b",
               $time, m_tdata, m_tlast);
    end else begin
      want = rows_due.pop_front();
      check_field("row_index",   int'(want.row),    int'(m_tdata[2:0]));
      check_field("digit_count", int'(want.count),  int'(m_tdata[5:3]));
      check_field("pixels_pos0", int'(want.pix[0]), int'(m_tdata[10:6]));
      check_field("pixels_pos1", int'(want.pix[1]), int'(m_tdata[15:11]));
      check_field("pixels_pos2", int'(want.pix[2]), int'(m_tdata[20:16]));
      check_field("pixels_pos3", int'(want.pix[3]), int'(m_tdata[25:21]));
      check_field("tdata pad",   0,                 int'(m_tdata[31:26]));
      check_field("last_row",    int'(want.last),   int'(m_tlast));
    end
  endtask

  // output side: check each transfer, then maybe hold off ready for a while
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (m_tvalid && m_tready) begin
      check_row();
      stall_draw = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall_draw > 0) begin
        stall_left = stall_draw;
        m_tready <= 1'b0;
      end
    end else if (!m_tready) begin
      if (stall_left > 0) begin
        stall_left--;
      end
      if (stall_left == 0) begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high across back-to-back transfers
  task automatic send_value(input logic [13:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    render_value(v);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // zero, every digit glyph, digit count boundaries, clamping, inner zeros
  task automatic test_directed();
    for (int d = 0; d <= 9; d++) begin
      send_value(14'(d));
    end
    send_value(14'd10);
    send_value(14'd99);
    send_value(14'd100);
    send_value(14'd999);
    send_value(14'd1000);
    send_value(14'd9090);
    send_value(14'd1234);
    send_value(14'd5678);
    send_value(14'd9999);
    send_value(14'd10000);
    send_value(14'h3fff);
    send_value(14'd0);
  endtask

  // full rate stretch, no gaps on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_value(14'($urandom_range(0, 16383)));
    end
    no_idle = 1'b0;
  endtask

  // sender holds off until every row of the previous values is out
  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      send_value(14'($urandom_range(0, 9999)));
    end
    wait_drained();
    send_value(14'($urandom_range(0, 9999)));
  endtask

  // spread over digit counts, clamp range and raw bit patterns
  task automatic test_random();
    logic [13:0] v;
    for (int i = 0; i < 86; i++) begin
      case ($urandom_range(0, 5))
        0: v = 14'($urandom_range(0, 9));
        1: v = 14'($urandom_range(10, 99));
        2: v = 14'($urandom_range(100, 999));
        3: v = 14'($urandom_range(1000, 9999));
        4: v = 14'($urandom_range(10000, 16383));
        default: v = 14'($urandom);
      endcase
      send_value(v);
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    mismatches = 0;
    cycles     = 0;
    no_idle    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random();
    wait_drained();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ddmr_pkg.sv
rtl/decimal_dot_matrix_renderer.sv
tb/sv/testbench.sv
